// ===== src/dshot4_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dshot4_pkg
// Shared widths, register indexes, reset values and types of the four channel
// DShot transmitter.
// ----------------------------------------------------------------------------
package dshot4_pkg;

    // channel and frame geometry
    localparam int CHANNELS       = 4;
    localparam int FRAME_BITS     = 16;
    localparam int MOTOR_WIDTH    = 2;
    localparam int THROTTLE_WIDTH = 11;
    localparam int NIBBLE_WIDTH   = 4;
    localparam int BIT_IDX_WIDTH  = $clog2(FRAME_BITS) + 1;

    // timer width default for the top level parameter
    localparam int TIMER_WIDTH_DEF = 16;

    // configuration port
    localparam int CFG_WIDTH     = 16;
    localparam int CFG_IDX_WIDTH = 2;

    localparam logic [CFG_IDX_WIDTH-1:0] REG_BIT_PERIOD      = 2'd0;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_ZERO_HIGH_TICKS = 2'd1;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_ONE_HIGH_TICKS  = 2'd2;

    localparam logic [CFG_WIDTH-1:0] BIT_PERIOD_RST      = 16'd119;
    localparam logic [CFG_WIDTH-1:0] ZERO_HIGH_TICKS_RST = 16'd35;
    localparam logic [CFG_WIDTH-1:0] ONE_HIGH_TICKS_RST  = 16'd71;

    // item action codes
    localparam logic ACT_LOAD = 1'b0;
    localparam logic ACT_TICK = 1'b1;

    // the last motor channel starts a frame when loaded while no frame is sending
    localparam logic [MOTOR_WIDTH-1:0] LAST_MOTOR = MOTOR_WIDTH'(CHANNELS - 1);

    typedef logic [FRAME_BITS-1:0] frame_t;
    typedef logic [CHANNELS-1:0]   lines_t;

    // timing registers as written
    typedef struct packed {
        logic [CFG_WIDTH-1:0] bit_period;
        logic [CFG_WIDTH-1:0] zero_high_ticks;
        logic [CFG_WIDTH-1:0] one_high_ticks;
    } timing_cfg_t;

endpackage

// ===== src/dshot4_in_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dshot4_in_if
// Input item channel: a motor load or one timer tick.
// ----------------------------------------------------------------------------
interface dshot4_in_if;
    import dshot4_pkg::*;

    logic                      valid;
    logic                      ready;
    logic                      action;
    logic [MOTOR_WIDTH-1:0]    motor;
    logic [THROTTLE_WIDTH-1:0] throttle;
    logic                      telemetry;

    modport source (output valid, output action, output motor, output throttle,
                    output telemetry, input ready);
    modport sink   (input valid, input action, input motor, input throttle,
                    input telemetry, output ready);
endinterface

// ===== src/dshot4_out_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dshot4_out_if
// Result item channel: line levels and status after each input item.
// ----------------------------------------------------------------------------
interface dshot4_out_if;
    import dshot4_pkg::*;

    logic         valid;
    logic         ready;
    logic [3:0]   pin_levels;
    logic         busy_res;
    logic         dropped;

    modport source (output valid, output pin_levels, output busy_res,
                    output dropped, input ready);
    modport sink   (input valid, input pin_levels, input busy_res,
                    input dropped, output ready);
endinterface

// ===== src/dshot4_pack.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dshot4_pack
// Packs throttle and telemetry bit into a 16-bit DShot frame with checksum.
// ----------------------------------------------------------------------------
module dshot4_pack
(
    input  logic [dshot4_pkg::THROTTLE_WIDTH-1:0] throttle,
    input  logic                                  telemetry,
    output dshot4_pkg::frame_t                    frame
);
    import dshot4_pkg::*;

    logic [THROTTLE_WIDTH:0] word;
    logic [NIBBLE_WIDTH-1:0] csum;

    // 12-bit word, then xor of its three nibbles
    assign word = {throttle, telemetry};
    assign csum = word[3:0] ^ word[7:4] ^ word[11:8];
    assign frame = {word, csum};

endmodule

// ===== src/dshot4_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dshot4_core
// Frame store, bit timer and line state; one item handled per cycle unless the
// output register stalls, with the result held in that output register.
// ----------------------------------------------------------------------------
module dshot4_core
#(
    parameter int TIMER_WIDTH = dshot4_pkg::TIMER_WIDTH_DEF
)
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  dshot4_pkg::timing_cfg_t               cfg,
    input  logic                                  item_valid,
    output logic                                  item_ready,
    input  logic                                  action,
    input  logic [dshot4_pkg::MOTOR_WIDTH-1:0]    motor,
    input  dshot4_pkg::frame_t                    frame,
    output logic                                  res_valid,
    input  logic                                  res_ready,
    output logic [3:0]                            pin_levels,
    output logic                                  busy_res,
    output logic                                  dropped
);
    import dshot4_pkg::*;

    frame_t                   pending_reg [CHANNELS];
    frame_t                   pending_next [CHANNELS];
    frame_t                   shift_reg [CHANNELS];
    frame_t                   shift_next [CHANNELS];
    logic [BIT_IDX_WIDTH-1:0] bit_idx_reg;
    logic [BIT_IDX_WIDTH-1:0] bit_idx_next;
    logic [BIT_IDX_WIDTH-1:0] bit_idx_inc;
    logic [TIMER_WIDTH-1:0]   tick_reg;
    logic [TIMER_WIDTH-1:0]   tick_next;
    logic [TIMER_WIDTH-1:0]   tick_wrap;
    logic                     sending_reg;
    logic                     sending_next;
    lines_t                   lines_reg;
    lines_t                   lines_next;
    logic                     dropped_next;

    logic                     out_valid_reg;
    logic [3:0]               pin_levels_reg;
    logic                     busy_reg;
    logic                     dropped_reg;

    logic [TIMER_WIDTH-1:0]   per;
    logic [TIMER_WIDTH-1:0]   zero_cmp;
    logic [TIMER_WIDTH-1:0]   one_cmp;
    logic                     accept;

    // timing registers taken modulo the timer width
    assign per      = TIMER_WIDTH'(cfg.bit_period);
    assign zero_cmp = TIMER_WIDTH'(cfg.zero_high_ticks);
    assign one_cmp  = TIMER_WIDTH'(cfg.one_high_ticks);

    // take an item whenever the output register is free or being emptied
    assign item_ready = !out_valid_reg || res_ready;
    assign accept     = item_valid && item_ready;

    assign tick_wrap   = (tick_reg >= per) ? '0 : tick_reg + 1'b1;
    assign bit_idx_inc = bit_idx_reg + 1'b1;

    // next state for one item
    always_comb
    begin
        pending_next = pending_reg;
        shift_next   = shift_reg;
        bit_idx_next = bit_idx_reg;
        tick_next    = tick_reg;
        sending_next = sending_reg;
        lines_next   = lines_reg;
        dropped_next = 1'b0;

        unique case (action)
            ACT_LOAD:
            begin
                pending_next[motor] = frame;
                if (motor == LAST_MOTOR)
                begin
                    if (sending_reg)
                    begin
                        dropped_next = 1'b1;
                    end
                    else
                    begin
                        shift_next   = pending_next;
                        bit_idx_next = '0;
                        tick_next    = per;
                        sending_next = 1'b1;
                    end
                end
            end
            ACT_TICK:
            begin
                if (sending_reg)
                begin
                    tick_next = tick_wrap;
                    // period start: all lines high
                    if (tick_wrap == '0)
                    begin
                        lines_next = '1;
                    end
                    // zero compare: lines sending a zero go low
                    if (tick_wrap == zero_cmp)
                    begin
                        for (int i = 0; i < CHANNELS; i++)
                        begin
                            if (!shift_reg[i][FRAME_BITS-1])
                            begin
                                lines_next[i] = 1'b0;
                            end
                        end
                    end
                    // one compare: all low, next bit
                    if (tick_wrap == one_cmp)
                    begin
                        lines_next = '0;
                        for (int i = 0; i < CHANNELS; i++)
                        begin
                            shift_next[i] = {shift_reg[i][FRAME_BITS-2:0], 1'b0};
                        end
                        if (bit_idx_inc >= BIT_IDX_WIDTH'(FRAME_BITS))
                        begin
                            bit_idx_next = '0;
                            sending_next = 1'b0;
                        end
                        else
                        begin
                            bit_idx_next = bit_idx_inc;
                        end
                    end
                end
            end
            default:
            begin
                dropped_next = 1'b0;
            end
        endcase
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CHANNELS; i++)
            begin
                pending_reg[i] <= '0;
                shift_reg[i]   <= '0;
            end
            bit_idx_reg <= '0;
            tick_reg    <= '0;
            sending_reg <= 1'b0;
            lines_reg   <= '0;
        end
        else if (accept)
        begin
            pending_reg <= pending_next;
            shift_reg   <= shift_next;
            bit_idx_reg <= bit_idx_next;
            tick_reg    <= tick_next;
            sending_reg <= sending_next;
            lines_reg   <= lines_next;
        end
    end

    // result valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (item_ready)
        begin
            out_valid_reg <= item_valid;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            pin_levels_reg <= 4'(lines_next);
            busy_reg       <= sending_next;
            dropped_reg    <= dropped_next;
        end
    end

    assign res_valid  = out_valid_reg;
    assign pin_levels = pin_levels_reg;
    assign busy_res   = busy_reg;
    assign dropped    = dropped_reg;

endmodule

// ===== src/dshot_four_channel_transmitter_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dshot_four_channel_transmitter_top
// Four channel DShot transmitter: motor loads pack frames, timer tick items
// drive all four lines at once, MSB first.
//
//   channel   direction   carries
//   in_ch     sink        action, motor, throttle, telemetry
//   out_ch    source      pin_levels, busy_res, dropped
//   cfg_*     write       bit_period, zero_high_ticks, one_high_ticks
//
// One item per cycle unless the result register stalls; its result appears
// in the output register in the cycle after acceptance, set by the single
// state update and result register. Reset clears all frames, the timer and
// the lines; timing registers return to 119, 35 and 71.
// A stalled result register holds in_ch.ready low until the result is taken.
// ----------------------------------------------------------------------------
module dshot_four_channel_transmitter_top
#(
    parameter int TIMER_WIDTH = dshot4_pkg::TIMER_WIDTH_DEF
)
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [dshot4_pkg::CFG_IDX_WIDTH-1:0] cfg_index,
    input  logic [dshot4_pkg::CFG_WIDTH-1:0]     cfg_wdata,
    dshot4_in_if.sink                            in_ch,
    dshot4_out_if.source                         out_ch
);
    import dshot4_pkg::*;

    timing_cfg_t cfg_reg;
    frame_t      frame;

    // timing registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.bit_period      <= BIT_PERIOD_RST;
            cfg_reg.zero_high_ticks <= ZERO_HIGH_TICKS_RST;
            cfg_reg.one_high_ticks  <= ONE_HIGH_TICKS_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_BIT_PERIOD:      cfg_reg.bit_period      <= cfg_wdata;
                REG_ZERO_HIGH_TICKS: cfg_reg.zero_high_ticks <= cfg_wdata;
                REG_ONE_HIGH_TICKS:  cfg_reg.one_high_ticks  <= cfg_wdata;
                default:             cfg_reg                 <= cfg_reg;
            endcase
        end
    end

    // frame packing for motor loads
    dshot4_pack u_pack
    (
        .throttle  (in_ch.throttle),
        .telemetry (in_ch.telemetry),
        .frame     (frame)
    );

    // frame store, timer and lines
    dshot4_core
    #(
        .TIMER_WIDTH (TIMER_WIDTH)
    )
    u_core
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .item_valid (in_ch.valid),
        .item_ready (in_ch.ready),
        .action     (in_ch.action),
        .motor      (in_ch.motor),
        .frame      (frame),
        .res_valid  (out_ch.valid),
        .res_ready  (out_ch.ready),
        .pin_levels (out_ch.pin_levels),
        .busy_res   (out_ch.busy_res),
        .dropped    (out_ch.dropped)
    );

endmodule
